// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL files; bpc_fifo.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge of clk, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/bpc_pkg.sv -----
`default_nettype none
package bpc_pkg;

	localparam int BPC_FIFO_DEPTH = 2;

	localparam logic [31:0] B6_OFFSET  = 32'd4000;
	localparam logic [31:0] B4_OFFSET  = 32'd32768;
	localparam logic [31:0] B7_SCALE   = 32'd50000;
	localparam logic [31:0] P_COEF_SQ  = 32'd3038;
	localparam logic [31:0] P_COEF_LIN = 32'hFFFF_E343;
	localparam logic [31:0] P_ROUND    = 32'd3791;

	localparam logic [1:0] REG_CAL_A = 2'd0;
	localparam logic [1:0] REG_CAL_B = 2'd1;
	localparam logic [1:0] REG_CAL_C = 2'd2;
	localparam logic [1:0] REG_OSS   = 2'd3;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
		return $unsigned($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[31:0];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/bpc_fifo.sv -----
`default_nettype none
`include "assert_macros.svh"
module bpc_fifo
	import bpc_pkg::*;
#(
	parameter int Width = 8,
	parameter int Depth = BPC_FIFO_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [Width-1:0] wdata,
	output logic                  full,
	input  wire logic             rd,
	output logic [Width-1:0]      rdata,
	output logic                  empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	logic [Width-1:0] mem_q [0:Depth-1];
	logic [PtrW-1:0]  wptr_q, rptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == CntFull);
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_CLK(a_cnt_range, cnt_q <= CntFull, "FIFO count exceeds depth")
	`ASSERT_CLK(a_last_pop, (cnt_q == CntW'(1) && do_rd && !do_wr) |=> empty, "FIFO not empty after last beat left")
	`ASSERT_CLK(a_fill, (full && !do_rd) |=> full, "FIFO lost a beat while full")
	`ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (cnt_q == '0), "FIFO not empty in reset")

endmodule
`default_nettype wire

// ----- hdl/bpc_div.sv -----
`default_nettype none
module bpc_div
	import bpc_pkg::*;
#(
	parameter int SideW = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             valid_in,
	input  wire logic [31:0]      num,
	input  wire logic [31:0]      den,
	input  wire logic [SideW-1:0] side_in,
	output logic                  valid_out,
	output logic [31:0]           quo,
	output logic [SideW-1:0]      side_out
);

	logic             valid_s [0:32];
	logic [31:0]      rem_s  [0:32];
	logic [31:0]      num_s  [0:32];
	logic [31:0]      den_s  [0:32];
	logic [31:0]      quo_s  [0:32];
	logic [SideW-1:0] side_s [0:32];

	assign valid_s[0] = valid_in;
	assign rem_s[0]  = '0;
	assign num_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < 32; i++) begin : g_stage
		logic [32:0] sh;
		logic [32:0] diff;
		logic        take;

		always_comb begin
			sh   = {rem_s[i], num_s[i][31]};
			diff = sh - {1'b0, den_s[i]};
			take = !diff[32];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? diff[31:0] : sh[31:0];
				num_s[i+1]  <= {num_s[i][30:0], 1'b0};
				den_s[i+1]  <= den_s[i];
				quo_s[i+1]  <= {quo_s[i][30:0], take};
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign valid_out = valid_s[32];
	assign quo       = quo_s[32];
	assign side_out  = side_s[32];

endmodule
`default_nettype wire

// ----- hdl/bpc_engine.sv -----
`default_nettype none
module bpc_engine
	import bpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [15:0] ut,
	input  wire logic [18:0] up,
	output logic             in_take,
	input  wire logic [63:0] cal_a,
	input  wire logic [63:0] cal_b,
	input  wire logic [31:0] cal_c,
	input  wire logic [1:0]  oss,
	input  wire logic        out_full,
	output logic             out_push,
	output logic [31:0]      out_temp,
	output logic [31:0]      out_pres,
	output logic             out_err
);

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic        en;

	assign ac1 = sx16(cal_a[15:0]);
	assign ac2 = sx16(cal_a[31:16]);
	assign ac3 = sx16(cal_a[47:32]);
	assign ac4 = {16'd0, cal_a[63:48]};
	assign ac5 = {16'd0, cal_b[15:0]};
	assign ac6 = {16'd0, cal_b[31:16]};
	assign b1  = sx16(cal_b[47:32]);
	assign b2  = sx16(cal_b[63:48]);
	assign mc  = sx16(cal_c[15:0]);
	assign md  = sx16(cal_c[31:16]);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s9, v_s10, v_s11, v_s12;

	assign en       = !(v_s12 && out_full);
	assign in_take  = en && in_valid;
	assign out_push = v_s12 && !out_full;

	// Stage 1: uncompensated temperature product.
	logic [31:0] x1_s1;
	logic [18:0] up_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= asr(mul32({16'd0, ut} - ac6, ac5), 5'd15);
			up_s1 <= up;
		end
	end

	// Stage 2: signed divide operands as magnitudes and sign.
	logic [31:0] den2, num2;
	logic [31:0] ua_s2, ub_s2, x1_s2;
	logic [18:0] up_s2;
	logic        neg_s2, e1_s2;
	assign den2 = x1_s1 + md;
	assign num2 = {mc[20:0], 11'd0};
	always_ff @(posedge clk) begin
		if (en) begin
			ua_s2  <= num2[31] ? 32'd0 - num2 : num2;
			ub_s2  <= den2[31] ? 32'd0 - den2 : den2;
			neg_s2 <= num2[31] ^ den2[31];
			e1_s2  <= (den2 == '0);
			x1_s2  <= x1_s1;
			up_s2  <= up_s1;
		end
	end

	localparam int Side1W = 53;
	logic              d1_v;
	logic [31:0]       q1;
	logic [Side1W-1:0] side1;
	bpc_div #(.SideW(Side1W)) u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s2),
		.num       (ua_s2),
		.den       (ub_s2),
		.side_in   ({neg_s2, e1_s2, x1_s2, up_s2}),
		.valid_out (d1_v),
		.quo       (q1),
		.side_out  (side1)
	);

	// Stage 3: temperature and b6.
	logic        d1_neg, d1_e;
	logic [31:0] d1_x1, x2_3, b5_3;
	logic [18:0] d1_up;
	logic [31:0] temp_s3, b6_s3;
	logic [18:0] up_s3;
	logic        e1_s3;
	assign {d1_neg, d1_e, d1_x1, d1_up} = side1;
	assign x2_3 = d1_neg ? 32'd0 - q1 : q1;
	assign b5_3 = d1_x1 + x2_3;
	always_ff @(posedge clk) begin
		if (en) begin
			temp_s3 <= asr(b5_3 + 32'd8, 5'd4);
			b6_s3   <= b5_3 - B6_OFFSET;
			up_s3   <= d1_up;
			e1_s3   <= d1_e;
		end
	end

	// Stage 4: products of b6.
	logic [31:0] sq_s4, x2a_s4, x1b_s4, temp_s4;
	logic [18:0] up_s4;
	logic        e1_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4   <= asr(mul32(b6_s3, b6_s3), 5'd12);
			x2a_s4  <= asr(mul32(ac2, b6_s3), 5'd11);
			x1b_s4  <= asr(mul32(ac3, b6_s3), 5'd13);
			temp_s4 <= temp_s3;
			up_s4   <= up_s3;
			e1_s4   <= e1_s3;
		end
	end

	// Stage 5: products of the squared term.
	logic [31:0] x1_s5, x2b_s5, x2a_s5, x1b_s5, temp_s5;
	logic [18:0] up_s5;
	logic        e1_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s5   <= asr(mul32(b2, sq_s4), 5'd11);
			x2b_s5  <= asr(mul32(b1, sq_s4), 5'd16);
			x2a_s5  <= x2a_s4;
			x1b_s5  <= x1b_s4;
			temp_s5 <= temp_s4;
			up_s5   <= up_s4;
			e1_s5   <= e1_s4;
		end
	end

	// Stage 6: b3 and the b4 term.
	logic [31:0] x3_6, b3_s6, x3p_s6, temp_s6;
	logic [18:0] up_s6;
	logic        e1_s6;
	assign x3_6 = x1_s5 + x2a_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			b3_s6   <= asr((({ac1[29:0], 2'b00} + x3_6) << oss) + 32'd2, 5'd2);
			x3p_s6  <= asr(x1b_s5 + x2b_s5 + 32'd2, 5'd2);
			temp_s6 <= temp_s5;
			up_s6   <= up_s5;
			e1_s6   <= e1_s5;
		end
	end

	// Stage 7: b4 and b7.
	logic [31:0] b4_s7, b7_s7, temp_s7;
	logic        e1_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			b4_s7   <= mul32(ac4, x3p_s6 + B4_OFFSET) >> 15;
			b7_s7   <= mul32({13'd0, up_s6} - b3_s6, B7_SCALE >> oss);
			temp_s7 <= temp_s6;
			e1_s7   <= e1_s6;
		end
	end

	localparam int Side2W = 34;
	logic              d2_v;
	logic [31:0]       num7, q2;
	logic [Side2W-1:0] side2;
	assign num7 = b7_s7[31] ? b7_s7 : {b7_s7[30:0], 1'b0};
	bpc_div #(.SideW(Side2W)) u_div_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s7),
		.num       (num7),
		.den       (b4_s7),
		.side_in   ({e1_s7 || (b4_s7 == '0), b7_s7[31], temp_s7}),
		.valid_out (d2_v),
		.quo       (q2),
		.side_out  (side2)
	);

	// Stage 9: pressure before the final correction.
	logic        d2_e, d2_post;
	logic [31:0] d2_temp;
	logic [31:0] p_s9, temp_s9;
	logic        e_s9;
	assign {d2_e, d2_post, d2_temp} = side2;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s9    <= d2_post ? {q2[30:0], 1'b0} : q2;
			temp_s9 <= d2_temp;
			e_s9    <= d2_e;
		end
	end

	// Stages 10 to 12: the polynomial correction.
	logic [31:0] t_9;
	logic [31:0] tt_s10, x2_s10, p_s10, temp_s10;
	logic        e_s10;
	assign t_9 = asr(p_s9, 5'd8);
	always_ff @(posedge clk) begin
		if (en) begin
			tt_s10   <= mul32(t_9, t_9);
			x2_s10   <= asr(mul32(P_COEF_LIN, p_s9), 5'd16);
			p_s10    <= p_s9;
			temp_s10 <= temp_s9;
			e_s10    <= e_s9;
		end
	end

	logic [31:0] x1_s11, x2_s11, p_s11, temp_s11;
	logic        e_s11;
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s11   <= asr(mul32(tt_s10, P_COEF_SQ), 5'd16);
			x2_s11   <= x2_s10;
			p_s11    <= p_s10;
			temp_s11 <= temp_s10;
			e_s11    <= e_s10;
		end
	end

	logic [31:0] pres_s12, temp_s12;
	logic        e_s12;
	always_ff @(posedge clk) begin
		if (en) begin
			pres_s12 <= p_s11 + asr(x1_s11 + x2_s11 + P_ROUND, 5'd4);
			temp_s12 <= temp_s11;
			e_s12    <= e_s11;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= d1_v;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s9  <= d2_v;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	assign out_err  = e_s12;
	assign out_temp = e_s12 ? '0 : temp_s12;
	assign out_pres = e_s12 ? '0 : pres_s12;

endmodule
`default_nettype wire

// ----- hdl/baro_pressure_temp_compensation_unit.sv -----
// Compensates one raw temperature and pressure pair per beat, using the calibration words
// and oversampling setting held in the configuration registers, and returns temperature in
// 0.1 degree units, pressure in pascals and a divide error flag. The block takes one beat
// per clock cycle unless a full result queue stalls it. The compensation chain holds the
// two 32-stage pipelined dividers. Small queues on the input and result sides let each
// side stall on its own.
`default_nettype none
module baro_pressure_temp_compensation_unit
	import bpc_pkg::*;
#(
	parameter int FifoDepth = BPC_FIFO_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] raw_temp,
	input  wire logic [18:0] raw_pressure,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      temp_decidegrees,
	output logic [31:0]      pressure_pa,
	output logic             divide_error
);

	logic [63:0] cal_a_q, cal_b_q;
	logic [31:0] cal_c_q;
	logic [1:0]  oss_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			oss_q   <= 2'd3;
		end else if (wr_en) begin
			case (paddr[4:3])
				REG_CAL_A: cal_a_q <= pwdata;
				REG_CAL_B: cal_b_q <= pwdata;
				REG_CAL_C: cal_c_q <= pwdata[31:0];
				REG_OSS:   oss_q   <= pwdata[1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_CAL_A: prdata = cal_a_q;
			REG_CAL_B: prdata = cal_b_q;
			REG_CAL_C: prdata = {32'd0, cal_c_q};
			REG_OSS:   prdata = {62'd0, oss_q};
			default:   prdata = '0;
		endcase
	end

	logic [34:0] in_data;
	logic        in_empty, in_take;

	bpc_fifo #(.Width(35), .Depth(FifoDepth)) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  ({raw_temp, raw_pressure}),
		.full   (full),
		.rd     (in_take),
		.rdata  (in_data),
		.empty  (in_empty)
	);

	logic        res_full, res_push, res_err;
	logic [31:0] res_temp, res_pres;

	bpc_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!in_empty),
		.ut       (in_data[34:19]),
		.up       (in_data[18:0]),
		.in_take  (in_take),
		.cal_a    (cal_a_q),
		.cal_b    (cal_b_q),
		.cal_c    (cal_c_q),
		.oss      (oss_q),
		.out_full (res_full),
		.out_push (res_push),
		.out_temp (res_temp),
		.out_pres (res_pres),
		.out_err  (res_err)
	);

	bpc_fifo #(.Width(65), .Depth(FifoDepth)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  ({res_err, res_pres, res_temp}),
		.full   (res_full),
		.rd     (pop),
		.rdata  ({divide_error, pressure_pa, temp_decidegrees}),
		.empty  (empty)
	);

endmodule
`default_nettype wire
